FILE: hw/rtl/bma_pkg.sv
// bma_pkg: shared constants, status codes and helper functions of the buddy allocator
// used by bma_ram users and by buddy_memory_allocator_unit; no dependencies
package bma_pkg;

  localparam int MAX_ORDER = 10;
  localparam int NLEV      = MAX_ORDER + 1;
  localparam int ADDR_W    = 10;              // block address width
  localparam int CNT_W     = ADDR_W + 1;      // free count, holds 2^ADDR_W
  localparam int LVL_W     = 4;               // order field width
  localparam int TBL_W     = 5;               // alloc table entry: order + 1, 0 = invalid
  localparam int SIZE_W    = 11;
  localparam int STORE_AW  = LVL_W + ADDR_W;  // {level, index}
  localparam int TBL_DEPTH = 1 << ADDR_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam logic [LVL_W-1:0] ORDER_RESET = LVL_W'(MAX_ORDER);

  localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_FREED      = 2'd2;
  localparam logic [1:0] ST_BAD_FREE   = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // smallest order whose block holds size (size in 1..2^MAX_ORDER)
  function automatic logic [LVL_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [LVL_W-1:0] x;
    x = LVL_W'(MAX_ORDER);
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if ((SIZE_W'(1) << k) >= size) x = LVL_W'(k);
    end
    return x;
  endfunction

  // pool order written through the config port, saturated
  function automatic logic [LVL_W-1:0] sat_order(input logic [LVL_W-1:0] v);
    return (v > LVL_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER) : v;
  endfunction

endpackage

FILE: hw/rtl/bma_ram.sv
// bma_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/buddy_memory_allocator_unit.sv
// buddy_memory_allocator_unit: top level of the buddy allocator
// depends on bma_pkg and bma_ram (free list store and allocation table)
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+---------------------------------------------
//  s_axis    | in        | s_tvalid/tready  | s_tdata: action, req_size, block_addr
//  m_axis    | out       | m_tvalid/tready  | m_tdata: status, addr, order, merges
//  config    | in        | cfg_wen          | cfg_wdata: pool_order
//
//  steps: an allocate pops the head of the chosen free list, shifts the entries left in
//    it down and splits once per order down to the request; a failed allocate or a free
//    beyond the pool ends after decode, a free of an unallocated start after the table
//    lookup; a free compares free-list entries with the buddy, pulls a found buddy
//    out by shifting the entries after it and merges a level up, then pushes the block.
//    all of it runs over the single store ram port pair walked by the sequencer.
//  reset and every pool_order write start a clearing pass over all 1024 entries of the
//    allocation table; s_tready stays low during it.
//  a finished result sits in the output register; the next transaction is taken
//    while it waits, and that one finishes only after the result has gone.
module buddy_memory_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [0] action, [11:1] req_size, [21:12] block_addr
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [1:0] status, [11:2] addr, [15:12] order, [19:16] merges
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata   // pool_order
);

  localparam int AW  = bma_pkg::ADDR_W;
  localparam int CW  = bma_pkg::CNT_W;
  localparam int LW  = bma_pkg::LVL_W;
  localparam int TW  = bma_pkg::TBL_W;
  localparam int SW  = bma_pkg::STORE_AW;

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_A_POP  = 4'd3;
  localparam logic [3:0] S_A_BLK  = 4'd4;
  localparam logic [3:0] S_SH_RD  = 4'd5;
  localparam logic [3:0] S_SH_WR  = 4'd6;
  localparam logic [3:0] S_A_SPLIT = 4'd7;
  localparam logic [3:0] S_F_LOOK = 4'd8;
  localparam logic [3:0] S_M_CHK  = 4'd9;
  localparam logic [3:0] S_SC_RD  = 4'd10;
  localparam logic [3:0] S_SC_CMP = 4'd11;
  localparam logic [3:0] S_M_NEXT = 4'd12;
  localparam logic [3:0] S_F_PUSH = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]    state;
  logic [LW-1:0] pool_order;
  logic [CW-1:0] counts [bma_pkg::NLEV];
  logic [AW-1:0] clr_cnt;

  // captured transaction
  logic                     act;
  logic [bma_pkg::SIZE_W-1:0] size;
  logic [AW-1:0]            baddr;

  // working registers
  logic [LW-1:0] lvl;
  logic [LW-1:0] x;
  logic [CW-1:0] idx;
  logic [AW-1:0] blk;
  logic [LW-1:0] merges;

  // result held until DONE
  logic [1:0]    res_status;
  logic [AW-1:0] res_addr;
  logic [LW-1:0] res_order;

  // ram ports
  logic          st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [AW-1:0] st_wdata, st_rdata;
  logic          tb_we;
  logic [AW-1:0] tb_waddr, tb_raddr;
  logic [TW-1:0] tb_wdata, tb_rdata;

  bma_ram #(.WIDTH(AW), .DEPTH(bma_pkg::STORE_DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  bma_ram #(.WIDTH(TW), .DEPTH(bma_pkg::TBL_DEPTH)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  // decode helpers
  logic [LW-1:0] lvl_dn;
  logic [CW-1:0] cnt_cur, cnt_dn;
  logic [LW-1:0] x_req;
  logic          fit_found;
  logic [LW-1:0] fit_lvl;
  logic          size_bad;
  logic          addr_bad;
  logic [AW-1:0] buddy;
  logic [CW-1:0] pool_size;

  assign lvl_dn    = lvl - LW'(1);
  assign cnt_cur   = counts[lvl];
  assign cnt_dn    = counts[lvl_dn];
  assign x_req     = bma_pkg::size_order(size);
  assign pool_size = CW'(1) << pool_order;
  assign size_bad  = (size == '0) || (size > pool_size);
  assign addr_bad  = ({1'b0, baddr} >= pool_size);
  assign buddy     = blk ^ (AW'(1) << lvl);

  // smallest non-empty level from the requested order up to the pool order
  always_comb begin
    fit_found = 1'b0;
    fit_lvl   = '0;
    for (int k = bma_pkg::MAX_ORDER; k >= 0; k--) begin
      if (LW'(k) >= x_req && LW'(k) <= pool_order && counts[k] != '0) begin
        fit_found = 1'b1;
        fit_lvl   = LW'(k);
      end
    end
  end

  // ram port steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = {lvl, idx[AW-1:0]};
    st_wdata = st_rdata;
    st_raddr = {lvl, idx[AW-1:0]};
    tb_we    = 1'b0;
    tb_waddr = baddr;
    tb_wdata = '0;
    tb_raddr = baddr;
    unique case (state)
      S_CLEAR: begin
        tb_we    = 1'b1;
        tb_waddr = clr_cnt;
        // fresh pool: one whole block at address zero
        st_we    = (clr_cnt == '0);
        st_waddr = {pool_order, AW'(0)};
        st_wdata = '0;
      end
      S_A_POP: st_raddr = {lvl, AW'(0)};
      S_SH_RD: st_raddr = {lvl, AW'(idx + CW'(1))};
      S_SH_WR: st_we = 1'b1;
      S_A_SPLIT: begin
        if (lvl > x) begin
          st_we    = !cnt_dn[CW-1];
          st_waddr = {lvl_dn, cnt_dn[AW-1:0]};
          st_wdata = blk + (AW'(1) << lvl_dn);
        end else begin
          tb_we    = 1'b1;
          tb_waddr = blk;
          tb_wdata = {1'b0, x} + TW'(1);
        end
      end
      S_F_LOOK: tb_we = (tb_rdata != '0);
      S_F_PUSH: begin
        st_we    = !cnt_cur[CW-1];
        st_waddr = {lvl, cnt_cur[AW-1:0]};
        st_wdata = blk;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      pool_order <= rst ? bma_pkg::ORDER_RESET : bma_pkg::sat_order(cfg_wdata);
      for (int k = 0; k < bma_pkg::NLEV; k++) begin
        counts[k] <= (LW'(k) == (rst ? bma_pkg::ORDER_RESET : bma_pkg::sat_order(cfg_wdata)))
                     ? CW'(1) : '0;
      end
      clr_cnt <= '0;
      state   <= S_CLEAR;
      if (rst) begin
        m_tvalid <= 1'b0;
      end
    end else begin
      // a result loaded in DONE takes over the slot that is emptied
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            act   <= s_tdata[0];
            size  <= s_tdata[11:1];
            baddr <= s_tdata[21:12];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          merges <= '0;
          if (act == bma_pkg::ACT_ALLOC) begin
            x <= x_req;
            if (size_bad || !fit_found) begin
              res_status <= bma_pkg::ST_ALLOC_FAIL;
              res_addr   <= '0;
              res_order  <= '0;
              state      <= S_DONE;
            end else begin
              lvl   <= fit_lvl;
              state <= S_A_POP;
            end
          end else if (addr_bad) begin
            res_status <= bma_pkg::ST_BAD_FREE;
            res_addr   <= baddr;
            res_order  <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_F_LOOK;   // table read issued this cycle
          end
        end
        S_A_POP: state <= S_A_BLK;
        S_A_BLK: begin
          blk         <= st_rdata;
          counts[lvl] <= cnt_cur - CW'(1);
          idx         <= '0;
          state       <= (cnt_cur > CW'(1)) ? S_SH_RD : S_A_SPLIT;
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          // counts[lvl] already holds the shortened length
          idx <= idx + CW'(1);
          if (idx + CW'(1) < cnt_cur) begin
            state <= S_SH_RD;
          end else begin
            state <= (act == bma_pkg::ACT_ALLOC) ? S_A_SPLIT : S_M_NEXT;
          end
        end
        S_A_SPLIT: begin
          if (lvl > x) begin
            if (!cnt_dn[CW-1]) counts[lvl_dn] <= cnt_dn + CW'(1);
            lvl <= lvl_dn;
          end else begin
            res_status <= bma_pkg::ST_ALLOC_OK;
            res_addr   <= blk;
            res_order  <= x;
            state      <= S_DONE;
          end
        end
        S_F_LOOK: begin
          res_addr <= baddr;
          if (tb_rdata == '0) begin
            res_status <= bma_pkg::ST_BAD_FREE;
            res_order  <= '0;
            state      <= S_DONE;
          end else begin
            res_status <= bma_pkg::ST_FREED;
            res_order  <= LW'(tb_rdata - TW'(1));
            lvl        <= LW'(tb_rdata - TW'(1));
            blk        <= baddr;
            state      <= S_M_CHK;
          end
        end
        S_M_CHK: begin
          idx <= '0;
          if (lvl < pool_order && cnt_cur != '0) begin
            state <= S_SC_RD;
          end else begin
            state <= S_F_PUSH;
          end
        end
        S_SC_RD: state <= S_SC_CMP;
        S_SC_CMP: begin
          if (st_rdata == buddy) begin
            counts[lvl] <= cnt_cur - CW'(1);
            state       <= (idx + CW'(1) < cnt_cur) ? S_SH_RD : S_M_NEXT;
          end else begin
            idx <= idx + CW'(1);
            state <= (idx + CW'(1) < cnt_cur) ? S_SC_RD : S_F_PUSH;
          end
        end
        S_M_NEXT: begin
          blk    <= blk & ~(AW'(1) << lvl);
          lvl    <= lvl + LW'(1);
          merges <= merges + LW'(1);
          state  <= S_M_CHK;
        end
        S_F_PUSH: begin
          if (!cnt_cur[CW-1]) counts[lvl] <= cnt_cur + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, merges, res_order, res_addr, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the top level, above a smaller pool order, never holds a free block
  a_no_high_blocks: assert property (@(posedge clk) disable iff (rst)
    (pool_order < LW'(bma_pkg::MAX_ORDER)) |-> (counts[bma_pkg::MAX_ORDER] == '0))
    else $error("free block above pool order");

  // splitting never goes below the requested order
  a_split_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPLIT) |-> (lvl >= x))
    else $error("split below requested order");

  // a free cannot merge past the pool order
  a_merge_ceiling: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == bma_pkg::ST_FREED)
      |-> ({1'b0, m_tdata[15:12]} + {1'b0, m_tdata[19:16]} <= {1'b0, pool_order}))
    else $error("merged past pool order");

endmodule
